// File: rtl/core/salsa20_stream_xor_assert.svh
// ---------------------------------------------------------------------------
// Salsa20 stream XOR assertion macros
// Shared concurrent assertion forms for the stream XOR checker.
// ---------------------------------------------------------------------------
`ifndef SALSA20_STREAM_XOR_ASSERT_SVH
`define SALSA20_STREAM_XOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define S20SX_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define S20SX_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/s20sx_pkg.sv
// ---------------------------------------------------------------------------
// Salsa20 stream XOR package
// Types, constants and round functions shared by the stream XOR block.
// ---------------------------------------------------------------------------
package s20sx_pkg;

  localparam int DATA_W      = 64;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int ROUND_COUNT = 20;
  // odd round counts round up to whole double rounds
  localparam int ROUNDS_RUN  = 2 * ((ROUND_COUNT + 1) / 2);
  localparam int RND_W       = (ROUNDS_RUN > 1) ? $clog2(ROUNDS_RUN) : 1;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CTR    = 3'd5;

  typedef logic [15:0][31:0] block_t;
  typedef logic [3:0][31:0]  quad_t;
  typedef logic [3:0][63:0]  key_t;
  typedef logic [2:0]        pos_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic latch;       // capture the input beat
    logic reload_ctr;  // load the start counter
    logic load_init;   // load the initial block into the working words
    logic do_round;    // run one round on the working words
    logic row_sel;     // 0: column round, 1: row round
    logic feed;        // feed-forward add into the keystream, bump counter
    logic emit;        // write the output register
    pos_t pos;         // word position of the held beat
  } dp_cmd_t;

  function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  function automatic quad_t quarter(quad_t q);
    logic [31:0] a, b, c, d;
    a = q[0];
    b = q[1];
    c = q[2];
    d = q[3];
    b = b ^ rotl(a + d, 5'd7);
    c = c ^ rotl(b + a, 5'd9);
    d = d ^ rotl(c + b, 5'd13);
    a = a ^ rotl(d + c, 5'd18);
    return {d, c, b, a};
  endfunction

  function automatic block_t qr_at(block_t w, logic [3:0] ia, logic [3:0] ib,
                                   logic [3:0] ic, logic [3:0] id);
    block_t r;
    quad_t  q;
    r = w;
    q = quarter({w[id], w[ic], w[ib], w[ia]});
    r[ia] = q[0];
    r[ib] = q[1];
    r[ic] = q[2];
    r[id] = q[3];
    return r;
  endfunction

  function automatic block_t column_round(block_t w);
    block_t r;
    r = qr_at(w, 4'd0,  4'd4,  4'd8,  4'd12);
    r = qr_at(r, 4'd5,  4'd9,  4'd13, 4'd1);
    r = qr_at(r, 4'd10, 4'd14, 4'd2,  4'd6);
    r = qr_at(r, 4'd15, 4'd3,  4'd7,  4'd11);
    return r;
  endfunction

  function automatic block_t row_round(block_t w);
    block_t r;
    r = qr_at(w, 4'd0,  4'd1,  4'd2,  4'd3);
    r = qr_at(r, 4'd5,  4'd6,  4'd7,  4'd4);
    r = qr_at(r, 4'd10, 4'd11, 4'd8,  4'd9);
    r = qr_at(r, 4'd15, 4'd12, 4'd13, 4'd14);
    return r;
  endfunction

  function automatic block_t make_init(key_t key, logic [63:0] nonce, logic [63:0] ctr);
    block_t b;
    b[0]  = SIGMA0;
    b[1]  = key[0][31:0];
    b[2]  = key[0][63:32];
    b[3]  = key[1][31:0];
    b[4]  = key[1][63:32];
    b[5]  = SIGMA1;
    b[6]  = nonce[31:0];
    b[7]  = nonce[63:32];
    b[8]  = ctr[31:0];
    b[9]  = ctr[63:32];
    b[10] = SIGMA2;
    b[11] = key[2][31:0];
    b[12] = key[2][63:32];
    b[13] = key[3][31:0];
    b[14] = key[3][63:32];
    b[15] = SIGMA3;
    return b;
  endfunction

  // byte i survives when i < count; counts of eight and above keep all bytes
  function automatic logic [DATA_W-1:0] byte_mask(logic [COUNT_W-1:0] count);
    logic [DATA_W-1:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = {8{(COUNT_W'(i) < count)}};
    end
    return m;
  endfunction

endpackage

// File: rtl/core/s20sx_if.sv
// ---------------------------------------------------------------------------
// Salsa20 stream XOR channel interfaces
// Valid/ready channels for input beats, result beats and config writes.
// ---------------------------------------------------------------------------
interface s20sx_in_if import s20sx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_in;
  logic [COUNT_W-1:0] byte_count;
  logic               starts_message;

  modport source (output valid, data_in, byte_count, starts_message, input ready);
  modport sink   (input valid, data_in, byte_count, starts_message, output ready);
endinterface

interface s20sx_out_if import s20sx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_out;
  logic [COUNT_W-1:0] out_count;

  modport source (output valid, data_out, out_count, input ready);
  modport sink   (input valid, data_out, out_count, output ready);
endinterface

interface s20sx_cfg_if import s20sx_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/s20sx_dp.sv
// ---------------------------------------------------------------------------
// Salsa20 stream XOR datapath
// Config registers, block counter, round unit, keystream store, output reg.
// ---------------------------------------------------------------------------
module s20sx_dp import s20sx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic [DATA_W-1:0]    in_data,
  input  logic [COUNT_W-1:0]   in_count,
  input  dp_cmd_t              cmd,
  output logic [DATA_W-1:0]    out_data,
  output logic [COUNT_W-1:0]   out_count
);

  key_t               key_r;
  logic [63:0]        nonce_r;
  logic [63:0]        start_ctr_r;
  logic [63:0]        ctr_r;
  logic [63:0]        ctr_sel;
  block_t             init_w;
  block_t             ww_r;
  logic [7:0][63:0]   ks_r;
  logic [7:0][63:0]   ks_nxt;
  logic [DATA_W-1:0]  hold_data_r;
  logic [COUNT_W-1:0] hold_count_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [COUNT_W-1:0] out_count_r;

  assign ctr_sel = cmd.reload_ctr ? start_ctr_r : ctr_r;
  assign init_w  = make_init(key_r, nonce_r, ctr_sel);

  // feed-forward: keystream word p is block words 2p and 2p+1
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      ks_nxt[p] = {ww_r[2*p+1] + init_w[2*p+1], ww_r[2*p] + init_w[2*p]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      nonce_r     <= '0;
      start_ctr_r <= '0;
      ctr_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LOW:      key_r[0]    <= cfg_wdata;
          CFG_KEY_MID_LOW:  key_r[1]    <= cfg_wdata;
          CFG_KEY_MID_HIGH: key_r[2]    <= cfg_wdata;
          CFG_KEY_HIGH:     key_r[3]    <= cfg_wdata;
          CFG_NONCE:        nonce_r     <= cfg_wdata;
          CFG_START_CTR:    start_ctr_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.latch && cmd.reload_ctr) begin
        ctr_r <= start_ctr_r;
      end else if (cmd.feed) begin
        ctr_r <= ctr_r + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hold_data_r  <= in_data;
      hold_count_r <= in_count;
    end
    if (cmd.load_init) begin
      ww_r <= init_w;
    end else if (cmd.do_round) begin
      ww_r <= cmd.row_sel ? row_round(ww_r) : column_round(ww_r);
    end
    if (cmd.feed) begin
      ks_r <= ks_nxt;
    end
    if (cmd.emit) begin
      out_data_r  <= (hold_data_r ^ ks_r[cmd.pos]) & byte_mask(hold_count_r);
      out_count_r <= hold_count_r;
    end
  end

  assign out_data  = out_data_r;
  assign out_count = out_count_r;

endmodule

// File: rtl/core/s20sx_ctrl.sv
// ---------------------------------------------------------------------------
// Salsa20 stream XOR controller
// Sequences capture, rounds, feed-forward and emit; owns the output valid.
// ---------------------------------------------------------------------------
module s20sx_ctrl import s20sx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_start,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  pos_t             pos_r, pos_nxt;
  pos_t             cur_pos_r, cur_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             slot_free;
  pos_t             pos_eff;
  logic             last_rnd;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign pos_eff   = in_start ? '0 : pos_r;
  assign last_rnd  = (rnd_r == RND_W'(ROUNDS_RUN - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (pos_eff == '0) ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        if (last_rnd) begin
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.pos     = cur_pos_r;
    cmd.row_sel = rnd_r[0];
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch      = accept;
        cmd.reload_ctr = accept && in_start;
        cmd.load_init  = accept && (pos_eff == '0);
      end
      ST_ROUND: cmd.do_round = 1'b1;
      ST_FEED:  cmd.feed     = 1'b1;
      ST_EMIT:  cmd.emit     = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    rnd_nxt       = (state_r == ST_ROUND) ? rnd_r + RND_W'(1) : '0;
    cur_pos_nxt   = accept ? pos_eff : cur_pos_r;
    pos_nxt       = cmd.emit ? cur_pos_r + 3'd1 : pos_r;
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      pos_r       <= '0;
      cur_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      pos_r       <= pos_nxt;
      cur_pos_r   <= cur_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/salsa20_stream_xor.sv
// ---------------------------------------------------------------------------
// Salsa20/20 stream XOR
// XORs 64-bit little-endian data beats with the Salsa20 keystream.
// ---------------------------------------------------------------------------
// One input beat carries eight data bytes, a valid byte count and a start
// flag; one result beat comes back per input beat, in order, holding the
// data XOR keystream with bytes past the count forced to zero and the count
// echoed. The start flag reloads the block counter from the start_counter
// register and restarts at word zero of a block. A beat at block word
// position one to seven is captured, then emitted once the output register
// is free. A beat at position zero first builds a new 64-byte block on the
// single shared round unit, one round per cycle; its steps are capture,
// 20 rounds, feed-forward and emit. The next input beat is taken while a
// finished result still waits in the output register. Config writes are
// always ready and take effect the next cycle; write them only while idle.
// ---------------------------------------------------------------------------
module salsa20_stream_xor import s20sx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  s20sx_in_if.sink    in_bus,
  s20sx_out_if.source out_bus,
  s20sx_cfg_if.sink   cfg_bus
);

  // flat handshake view, also used by the bound checker
  logic               in_valid;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready;
  logic [DATA_W-1:0]  out_data;
  logic [COUNT_W-1:0] out_count;
  logic               cfg_we;
  dp_cmd_t            cmd;

  assign in_valid  = in_bus.valid;
  assign out_ready = out_bus.ready;

  // config port never stalls
  assign cfg_bus.ready = 1'b1;
  assign cfg_we        = cfg_bus.valid;

  // sequencer: capture, round loop, feed-forward, emit
  s20sx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_start  (in_bus.starts_message),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // key/nonce/counter, working words, keystream block, output register
  s20sx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_bus.index),
    .cfg_wdata (cfg_bus.wdata),
    .in_data   (in_bus.data_in),
    .in_count  (in_bus.byte_count),
    .cmd       (cmd),
    .out_data  (out_data),
    .out_count (out_count)
  );

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_valid;
  assign out_bus.data_out  = out_data;
  assign out_bus.out_count = out_count;

endmodule

// File: rtl/core/s20sx_chk.sv
// ---------------------------------------------------------------------------
// Salsa20 stream XOR port checker
// Beat accounting and output masking checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "salsa20_stream_xor_assert.svh"

module s20sx_chk import s20sx_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  out_data,
  input logic [COUNT_W-1:0] out_count
);

  // beats taken in but not yet delivered
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `S20SX_ASSERT_IMP(a_no_phantom_out, clk, rst_n, out_valid, pend_r != 2'd0, "result beat without input")
  `S20SX_ASSERT_IMP(a_full_blocks_in, clk, rst_n, pend_r == 2'd2, !in_ready, "accepted a third beat")
  `S20SX_ASSERT_IMP(a_tail_zero, clk, rst_n, out_valid, (out_data & ~byte_mask(out_count)) == '0, "bytes past count not zero")
  `S20SX_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(out_count), "stalled result changed")

endmodule

bind salsa20_stream_xor s20sx_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .out_count (out_count)
);
